@@ rtl/threshold_masked_weighted_selector_core_macros.svh @@
// assertion macros for the threshold masked weighted selector
`ifndef THRESHOLD_MASKED_WEIGHTED_SELECTOR_CORE_MACROS_SVH
`define THRESHOLD_MASKED_WEIGHTED_SELECTOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TMWS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmws assertion failed");

// next-cycle implication, checked out of reset
`define TMWS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmws assertion failed");

`endif

@@ rtl/tmws_pkg.sv @@
// shared constants and types for the threshold masked weighted selector
package tmws_pkg;

  localparam int CHANNELS    = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int ENERGY_BITS = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_W       = 5;
  localparam int IDX_W       = $clog2(CHANNELS);
  localparam int CNT_W       = $clog2(CHANNELS + 1);
  localparam int SUM_W       = WEIGHT_BITS + $clog2(CHANNELS);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_CHOOSE = 1'b1;

  // token that walks the row of cells
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] acc;
    logic             any;
    logic [IDX_W-1:0] first;
    logic             found;
    logic [IDX_W-1:0] pick;
  } tok_t;

  // values broadcast to every cell for the request in flight
  typedef struct packed {
    logic                   pass2;
    logic [CNT_W-1:0]       n;
    logic [ENERGY_BITS-1:0] energy;
    logic [SUM_W-1:0]       scaled;
  } bcast_t;

  // table write broadcast
  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       idx;
    logic [WEIGHT_BITS-1:0] weight;
    logic [ENERGY_BITS-1:0] threshold;
  } wr_t;

  typedef struct packed {
    logic idle;
    logic in_pass;
  } sts_t;

endpackage

@@ rtl/tmws_cell.sv @@
// one channel cell: holds weight and threshold, updates the passing token
module tmws_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [tmws_pkg::IDX_W-1:0] my_idx,
  input  tmws_pkg::wr_t          wr,
  input  tmws_pkg::bcast_t       bc,
  input  tmws_pkg::tok_t         tok_in,
  output tmws_pkg::tok_t         tok_out
);
  import tmws_pkg::*;

  logic [WEIGHT_BITS-1:0] weight_r;
  logic [ENERGY_BITS-1:0] thresh_r;
  tok_t                   tok_r;
  tok_t                   tok_nxt;
  logic                   elig;
  logic [SUM_W-1:0]       hi;

  assign elig = (CNT_W'(my_idx) < bc.n) && (thresh_r < bc.energy);
  assign hi   = tok_in.acc + SUM_W'(weight_r);

  always_comb begin
    tok_nxt = tok_in;
    if (elig) begin
      if (!bc.pass2) begin
        // first pass: total of eligible weights
        if (!tok_in.any) begin
          tok_nxt.first = my_idx;
        end
        tok_nxt.any = 1'b1;
        tok_nxt.acc = hi;
      end else if (!tok_in.found) begin
        // second pass: half-open interval [acc, hi)
        if ((bc.scaled >= tok_in.acc) && (bc.scaled < hi)) begin
          tok_nxt.found = 1'b1;
          tok_nxt.pick  = my_idx;
        end
        tok_nxt.acc = hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= '0;
      thresh_r    <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      if (wr.en && (wr.idx == my_idx)) begin
        weight_r <= wr.weight;
        thresh_r <= wr.threshold;
      end
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.acc   <= tok_nxt.acc;
    tok_r.any   <= tok_nxt.any;
    tok_r.first <= tok_nxt.first;
    tok_r.found <= tok_nxt.found;
    tok_r.pick  <= tok_nxt.pick;
  end

  assign tok_out = tok_r;

endmodule

@@ rtl/tmws_ctrl.sv @@
// sequencer: request handshake, token injection, scaling and result register
module tmws_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tmws_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [tmws_pkg::IDX_W-1:0]       in_channel_index,
  input  logic [tmws_pkg::WEIGHT_BITS-1:0] in_weight,
  input  logic [tmws_pkg::ENERGY_BITS-1:0] in_threshold,
  input  logic [tmws_pkg::ENERGY_BITS-1:0] in_energy,
  input  logic [tmws_pkg::FRAC_BITS-1:0]   in_random_fraction,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tmws_pkg::IDX_W-1:0]       out_chosen_channel,
  output logic                             out_no_channel,
  output tmws_pkg::tok_t                   tok_head,
  input  tmws_pkg::tok_t                   tok_tail,
  output tmws_pkg::bcast_t                 bc,
  output tmws_pkg::wr_t                    wr,
  output tmws_pkg::sts_t                   sts
);
  import tmws_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PASS1 = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_PASS2 = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       n_r, n_nxt, n_eff;
  logic [ENERGY_BITS-1:0] energy_r, energy_nxt;
  logic [FRAC_BITS-1:0]   frac_r, frac_nxt;
  logic [SUM_W-1:0]       total_r, total_nxt;
  logic [SUM_W-1:0]       scaled_r, scaled_nxt;
  logic [IDX_W-1:0]       first_r, first_nxt;
  logic [IDX_W-1:0]       last_r, last_nxt;
  logic [IDX_W-1:0]       res_chan_r, res_chan_nxt;
  logic                   res_none_r, res_none_nxt;
  logic                   inj_r, inj_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]       out_chan_r, out_chan_nxt;
  logic                   out_none_r, out_none_nxt;
  logic [SUM_W+FRAC_BITS-1:0] prod;
  logic [IDX_W-1:0]       pick2;

  // a count of zero acts as one, above the table size as the table size
  always_comb begin
    if (cnt_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(cnt_r) > CNT_W'(CHANNELS)) begin
      n_eff = CNT_W'(CHANNELS);
    end else begin
      n_eff = CNT_W'(cnt_r);
    end
  end

  assign prod  = {{FRAC_BITS{1'b0}}, total_r} * {{SUM_W{1'b0}}, frac_r};
  assign pick2 = tok_tail.found ? tok_tail.pick : first_r;

  assign in_stall = (state_r != ST_IDLE);

  assign wr.en        = in_valid && (state_r == ST_IDLE) && (in_op == OP_WRITE);
  assign wr.idx       = in_channel_index;
  assign wr.weight    = in_weight;
  assign wr.threshold = in_threshold;

  assign bc.pass2  = (state_r == ST_PASS2);
  assign bc.n      = n_r;
  assign bc.energy = energy_r;
  assign bc.scaled = scaled_r;

  assign tok_head.valid = inj_r;
  assign tok_head.acc   = '0;
  assign tok_head.any   = 1'b0;
  assign tok_head.first = '0;
  assign tok_head.found = 1'b0;
  assign tok_head.pick  = '0;

  assign sts.idle    = (state_r == ST_IDLE);
  assign sts.in_pass = (state_r == ST_PASS1) || (state_r == ST_PASS2);

  assign out_valid          = out_valid_r;
  assign out_chosen_channel = out_chan_r;
  assign out_no_channel     = out_none_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    energy_nxt    = energy_r;
    frac_nxt      = frac_r;
    total_nxt     = total_r;
    scaled_nxt    = scaled_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    res_chan_nxt  = res_chan_r;
    res_none_nxt  = res_none_r;
    inj_nxt       = 1'b0;
    out_valid_nxt = out_valid_r;
    out_chan_nxt  = out_chan_r;
    out_none_nxt  = out_none_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_op == OP_CHOOSE)) begin
          energy_nxt = in_energy;
          frac_nxt   = in_random_fraction;
          n_nxt      = n_eff;
          if (n_eff == CNT_W'(1)) begin
            // single channel: repeat the last choice, no threshold check
            res_chan_nxt = last_r;
            res_none_nxt = 1'b0;
            state_nxt    = ST_DONE;
          end else begin
            inj_nxt   = 1'b1;
            state_nxt = ST_PASS1;
          end
        end
      end
      ST_PASS1: begin
        if (tok_tail.valid) begin
          if (!tok_tail.any) begin
            res_chan_nxt = last_r;
            res_none_nxt = 1'b1;
            state_nxt    = ST_DONE;
          end else if (tok_tail.acc == '0) begin
            // eligible but weightless: lowest eligible index wins
            res_chan_nxt = tok_tail.first;
            res_none_nxt = 1'b0;
            last_nxt     = tok_tail.first;
            state_nxt    = ST_DONE;
          end else begin
            total_nxt = tok_tail.acc;
            first_nxt = tok_tail.first;
            state_nxt = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        scaled_nxt = prod[SUM_W+FRAC_BITS-1:FRAC_BITS];
        inj_nxt    = 1'b1;
        state_nxt  = ST_PASS2;
      end
      ST_PASS2: begin
        if (tok_tail.valid) begin
          res_chan_nxt = pick2;
          res_none_nxt = 1'b0;
          last_nxt     = pick2;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_chan_nxt  = res_chan_r;
          out_none_nxt  = res_none_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= CFG_W'(1);
      last_r      <= '0;
      inj_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      last_r      <= last_nxt;
      inj_r       <= inj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    energy_r   <= energy_nxt;
    frac_r     <= frac_nxt;
    total_r    <= total_nxt;
    scaled_r   <= scaled_nxt;
    first_r    <= first_nxt;
    res_chan_r <= res_chan_nxt;
    res_none_r <= res_none_nxt;
    out_chan_r <= out_chan_nxt;
    out_none_r <= out_none_nxt;
  end

endmodule

@@ rtl/threshold_masked_weighted_selector_core.sv @@
// top level: row of channel cells driven by the sequencer
//
//  channel  handshake           payload
//  in       in_valid/in_stall   in_op, in_channel_index, in_weight, in_threshold,
//                               in_energy, in_random_fraction
//  out      out_valid/out_stall out_chosen_channel, out_no_channel
//  cfg      cfg_we              cfg_wdata (channels in use)
//
// a write request is taken while idle and gives no result
// a choose request makes two token walks through the row of sixteen cells,
// with a multiply state between them, then loads the result register
// single channel in use, or nothing eligible, ends after the first walk or at once
// reset clears the tables, the last choice and sets channels in use to one
// a stalled result waits in the output register while the next request runs
`include "threshold_masked_weighted_selector_core_macros.svh"

module threshold_masked_weighted_selector_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tmws_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [tmws_pkg::IDX_W-1:0]       in_channel_index,
  input  logic [tmws_pkg::WEIGHT_BITS-1:0] in_weight,
  input  logic [tmws_pkg::ENERGY_BITS-1:0] in_threshold,
  input  logic [tmws_pkg::ENERGY_BITS-1:0] in_energy,
  input  logic [tmws_pkg::FRAC_BITS-1:0]   in_random_fraction,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tmws_pkg::IDX_W-1:0]       out_chosen_channel,
  output logic                             out_no_channel
);
  import tmws_pkg::*;

  tok_t                tok [0:CHANNELS];
  logic [CHANNELS-1:0] tok_valid_vec;
  bcast_t              bc;
  wr_t                 wr;
  sts_t                sts;

  tmws_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_channel_index   (in_channel_index),
    .in_weight          (in_weight),
    .in_threshold       (in_threshold),
    .in_energy          (in_energy),
    .in_random_fraction (in_random_fraction),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_chosen_channel (out_chosen_channel),
    .out_no_channel     (out_no_channel),
    .tok_head           (tok[0]),
    .tok_tail           (tok[CHANNELS]),
    .bc                 (bc),
    .wr                 (wr),
    .sts                (sts)
  );

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    tmws_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (IDX_W'(g)),
      .wr      (wr),
      .bc      (bc),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
    assign tok_valid_vec[g] = tok[g+1].valid;
  end

  // only one request is ever walking the row
  `TMWS_ASSERT_NOW(a_single_token, 1'b1, $countones(tok_valid_vec) <= 1)
  // the token leaves the row only while the sequencer waits for it
  `TMWS_ASSERT_NOW(a_tail_in_pass, tok[CHANNELS].valid, sts.in_pass)
  // a table write never occupies the sequencer
  `TMWS_ASSERT_NEXT(a_write_one_cycle, in_valid && !in_stall && (in_op == OP_WRITE), sts.idle)

endmodule
